>>> hw/rtl/ffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types for the first-fit free range allocator: result codes,
// sequencer states and the flags of the fit unit.
// ----------------------------------------------------------------------------
package ffa_pkg;

	// result codes carried in the output tuser
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_RANGE = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_NO_FIT    = 2'd3
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	// outcome of one range compare
	typedef struct packed {
		logic fit;
		logic exact;
	} fit_flags_t;

endpackage : ffa_pkg
`default_nettype wire

>>> hw/rtl/ffa_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_fit
// Shared compare unit: length of one stored range against the requested
// size, plus the new start of the range after the allocation.
// ----------------------------------------------------------------------------
module ffa_fit import ffa_pkg::*; #(
	parameter int ADDR_BITS = 22
) (
	input  wire logic [ADDR_BITS-1:0] range_start,
	input  wire logic [ADDR_BITS-1:0] range_end,
	input  wire logic [ADDR_BITS-1:0] request_size,
	output fit_flags_t                flags,
	output logic      [ADDR_BITS-1:0] next_start
);

	logic [ADDR_BITS-1:0] len;

	// range length, empty when the end does not lie above the start
	assign len = (range_end > range_start) ? (range_end - range_start) : '0;

	assign flags.fit   = (request_size <= len);
	assign flags.exact = (request_size == len);

	// start after taking the low part, wrapped to the address width
	assign next_start = range_start + request_size;

endmodule : ffa_fit
`default_nettype wire

>>> hw/rtl/first_fit_free_range_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_free_range_allocator_top
// First-fit allocator over a table of free address ranges.
// ----------------------------------------------------------------------------
// Each input transfer either frees a range [start, end) or requests an
// allocation, and produces exactly one output transfer with a status code
// and, on a successful allocation, the allocated [start, end). Ranges are
// held in a single-port-write memory in order of arrival; the newest range
// is searched first. One item is worked on at a time and s_tready is low
// while it runs. An allocation reads one entry per cycle through the
// shared compare unit until a range fits or all N entries held have been
// read, and an exact fit that removes an entry below the newest then moves
// each newer entry down one place. A finished result sits in the output
// register while the next item may already be accepted.
// ----------------------------------------------------------------------------
module first_fit_free_range_allocator_top import ffa_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDR_BITS     = 22,
	localparam int IN_TD_W  = ((3 * ADDR_BITS + 7) / 8) * 8,
	localparam int OUT_TD_W = ((2 * ADDR_BITS + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// range_start, range_end, request_size, zero fill
	input  wire logic [IN_TD_W-1:0]  s_tdata,
	// func
	input  wire logic                s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// alloc_start, alloc_end, zero fill
	output logic      [OUT_TD_W-1:0] m_tdata,
	// status
	output logic      [1:0]          m_tuser
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ENT_W = 2 * ADDR_BITS;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     rem_q;
	logic [IDX_W-1:0]     dptr_q;
	logic                 dvld_q;
	logic [ADDR_BITS-1:0] size_q;
	status_t              res_status_q;
	logic [ADDR_BITS-1:0] res_start_q;
	logic [ADDR_BITS-1:0] res_end_q;
	logic                 m_tvalid_q;
	status_t              m_status_q;
	logic [ADDR_BITS-1:0] m_start_q;
	logic [ADDR_BITS-1:0] m_end_q;

	logic [ENT_W-1:0]     mem_q [TABLE_ENTRIES];
	logic [ENT_W-1:0]     rd_data_q;
	logic                 rd_en;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENT_W-1:0]     wr_data;

	logic                 accept;
	logic                 issue;
	logic [ADDR_BITS-1:0] in_start;
	logic [ADDR_BITS-1:0] in_end;
	logic [ADDR_BITS-1:0] in_size;
	logic                 in_bad;
	logic                 tbl_full;
	logic [ADDR_BITS-1:0] ent_start;
	logic [ADDR_BITS-1:0] ent_end;
	logic [ADDR_BITS-1:0] next_start;
	fit_flags_t           flags;
	logic [IDX_W-1:0]     last_idx;

	// input unpacking
	assign in_start = s_tdata[ADDR_BITS-1:0];
	assign in_end   = s_tdata[2*ADDR_BITS-1:ADDR_BITS];
	assign in_size  = s_tdata[3*ADDR_BITS-1:2*ADDR_BITS];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_bad   = (in_start >= in_end);
	assign tbl_full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// one table read per cycle while scanning or moving entries
	assign issue = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rem_q != '0);
	assign rd_en = issue;

	assign ent_start = rd_data_q[ADDR_BITS-1:0];
	assign ent_end   = rd_data_q[ENT_W-1:ADDR_BITS];

	// shared compare unit
	ffa_fit #(
		.ADDR_BITS(ADDR_BITS)
	) u_fit (
		.range_start (ent_start),
		.range_end   (ent_end),
		.request_size(size_q),
		.flags       (flags),
		.next_start  (next_start)
	);

	// table write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = dptr_q;
		wr_data = rd_data_q;
		priority if (accept && !s_tuser && !in_bad && !tbl_full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
			wr_data = {in_end, in_start};
		end else if ((state_q == S_SCAN) && dvld_q && flags.fit && !flags.exact) begin
			wr_en   = 1'b1;
			wr_addr = dptr_q;
			wr_data = {ent_end, next_start};
		end else if ((state_q == S_SHIFT) && dvld_q) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(dptr_q - 1'b1);
			wr_data = rd_data_q;
		end else begin
			wr_en = 1'b0;
		end
	end

	// range table, newest entry at the highest used address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[ptr_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			rem_q        <= '0;
			dptr_q       <= '0;
			dvld_q       <= 1'b0;
			size_q       <= '0;
			res_status_q <= STATUS_OK;
			res_start_q  <= '0;
			res_end_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					dvld_q <= 1'b0;
					if (accept) begin
						res_start_q <= '0;
						res_end_q   <= '0;
						size_q      <= in_size;
						if (!s_tuser) begin
							state_q <= S_FINISH;
							if (in_bad) begin
								res_status_q <= STATUS_BAD_RANGE;
							end else if (tbl_full) begin
								res_status_q <= STATUS_FULL;
							end else begin
								res_status_q <= STATUS_OK;
								count_q      <= count_q + 1'b1;
							end
						end else if (count_q == '0) begin
							res_status_q <= STATUS_NO_FIT;
							state_q      <= S_FINISH;
						end else begin
							ptr_q   <= last_idx;
							rem_q   <= count_q;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q  <= ptr_q - 1'b1;
						rem_q  <= rem_q - 1'b1;
						dptr_q <= ptr_q;
						dvld_q <= 1'b1;
					end else begin
						dvld_q <= 1'b0;
					end
					// compare the entry read last cycle
					if (dvld_q) begin
						if (flags.fit) begin
							res_status_q <= STATUS_OK;
							res_start_q  <= ent_start;
							res_end_q    <= next_start;
							if (!flags.exact) begin
								state_q <= S_FINISH;
							end else if (dptr_q == last_idx) begin
								count_q <= count_q - 1'b1;
								state_q <= S_FINISH;
							end else begin
								// close the gap: newer entries move down one place
								ptr_q   <= IDX_W'(dptr_q + 1'b1);
								rem_q   <= count_q - CNT_W'(dptr_q) - CNT_W'(1);
								dvld_q  <= 1'b0;
								state_q <= S_SHIFT;
							end
						end else if (rem_q == '0) begin
							res_status_q <= STATUS_NO_FIT;
							res_start_q  <= '0;
							res_end_q    <= '0;
							state_q      <= S_FINISH;
						end
					end
				end
				S_SHIFT: begin
					if (issue) begin
						ptr_q  <= ptr_q + 1'b1;
						rem_q  <= rem_q - 1'b1;
						dptr_q <= ptr_q;
						dvld_q <= 1'b1;
					end else begin
						dvld_q <= 1'b0;
					end
					if (!issue && !dvld_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					dvld_q <= 1'b0;
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_status_q <= STATUS_OK;
			m_start_q  <= '0;
			m_end_q    <= '0;
		end else begin
			if ((state_q == S_FINISH) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				m_status_q <= res_status_q;
				m_start_q  <= res_start_q;
				m_end_q    <= res_end_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TD_W'({m_end_q, m_start_q});
	assign m_tuser  = m_status_q;

endmodule : first_fit_free_range_allocator_top
`default_nettype wire

>>> tb/first_fit_free_range_allocator_top_test.sv
// ----------------------------------------------------------------------------
// first_fit_free_range_allocator_top_test
// Drives free and allocate transfers into the first-fit allocator and
// checks every result against a cycle-free copy of the range table kept
// here. A short table of directed items covers the edge cases. Random
// phases follow that fill, drain and mix the table or send unshaped random
// items, with random gaps on both streams.
// ----------------------------------------------------------------------------
module first_fit_free_range_allocator_top_test import ffa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES = 16;
	localparam int ADDR_BITS     = 22;
	localparam int IN_TD_W       = 72;
	localparam int OUT_TD_W      = 48;
	localparam int RANDOM_ITEMS  = 900;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int DIR_ROWS      = 22;

	localparam logic FUNC_FREE  = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

	// phase kinds of the random part
	localparam int PH_FILL  = 0;
	localparam int PH_DRAIN = 1;
	localparam int PH_MIX   = 2;
	localparam int PH_NOISE = 3;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef struct packed {
		status_t status;
		addr_t   start_addr;
		addr_t   end_addr;
	} alloc_result_t;

	typedef struct packed {
		logic          func;
		addr_t         rs;
		addr_t         re;
		addr_t         sz;
		logic          fixed;
		alloc_result_t res;
	} dir_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_TD_W-1:0]  s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TD_W-1:0] m_tdata;
	logic [1:0]          m_tuser;

	// free range table as the block should hold it, newest first
	addr_t free_lo [TABLE_ENTRIES];
	addr_t free_hi [TABLE_ENTRIES];
	int    used_count = 0;

	alloc_result_t pending_results [$];
	int            error_count   = 0;
	int            cycle_count   = 0;
	bit            tx_idle_on    = 1'b1;
	bit            rx_idle_on    = 1'b1;
	int            rx_stall_left = 0;

	first_fit_free_range_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d",
			what, got, want, cycle_count);
		error_count++;
	endtask

	// apply one item to the table copy and return the result it gives
	function automatic alloc_result_t apply_to_table(input logic func, input addr_t rs,
			input addr_t re, input addr_t sz);
		alloc_result_t res;
		addr_t         span;
		bit            found;
		res = '{STATUS_OK, '0, '0};
		found = 1'b0;
		if (func == FUNC_FREE) begin
			if (rs >= re) begin
				res.status = STATUS_BAD_RANGE;
			end else if (used_count >= TABLE_ENTRIES) begin
				res.status = STATUS_FULL;
			end else begin
				for (int i = used_count; i > 0; i--) begin
					free_lo[i] = free_lo[i-1];
					free_hi[i] = free_hi[i-1];
				end
				free_lo[0] = rs;
				free_hi[0] = re;
				used_count++;
			end
		end else begin
			res.status = STATUS_NO_FIT;
			for (int i = 0; i < used_count && !found; i++) begin
				span = free_hi[i] - free_lo[i];
				if (sz <= span) begin
					found = 1'b1;
					res = '{STATUS_OK, free_lo[i], free_lo[i] + sz};
					if (sz < span) begin
						free_lo[i] = free_lo[i] + sz;
					end else begin
						// exact fit drops the entry, older ones move up
						for (int j = i; j + 1 < used_count; j++) begin
							free_lo[j] = free_lo[j+1];
							free_hi[j] = free_hi[j+1];
						end
						used_count--;
					end
				end
			end
		end
		return res;
	endfunction

	// one input transfer after a random gap, then log what it should give
	task automatic send_item(input logic func, input addr_t rs, input addr_t re,
			input addr_t sz, input logic fixed, input alloc_result_t fixed_res);
		int            gap;
		alloc_result_t res;
		gap = tx_idle_on ? $urandom_range(13, 0) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= IN_TD_W'({sz, re, rs});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = apply_to_table(func, rs, re, sz);
		pending_results.push_back(fixed ? fixed_res : res);
	endtask

	// result side: random stalls and the field checks
	always @(posedge clk) begin
		alloc_result_t want;
		int            stall;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, status", 32'(m_tuser), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				if (m_tdata[ADDR_BITS-1:0] != want.start_addr)
					report_mismatch("alloc_start", 32'(m_tdata[ADDR_BITS-1:0]),
						32'(want.start_addr));
				if (m_tdata[2*ADDR_BITS-1:ADDR_BITS] != want.end_addr)
					report_mismatch("alloc_end", 32'(m_tdata[2*ADDR_BITS-1:ADDR_BITS]),
						32'(want.end_addr));
			end
			stall = rx_idle_on ? $urandom_range(13, 0) : 0;
			if (stall == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_stall_left <= stall - 1;
			end
		end else if (!m_tready && arst_n) begin
			if (rx_stall_left == 0)
				m_tready <= 1'b1;
			else
				rx_stall_left <= rx_stall_left - 1;
		end
	end

	// directed items, fixed results only where they are obvious
	dir_row_t dir_rows [DIR_ROWS] = '{
		// empty table after reset
		'{FUNC_ALLOC, ADDR_MAX, 22'h0, 22'h1, 1'b1, '{STATUS_NO_FIT, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h15555, 22'h2aaaa, 22'h0, 1'b1, '{STATUS_NO_FIT, 22'h0, 22'h0}},
		// start not below end
		'{FUNC_FREE, 22'h0, 22'h0, ADDR_MAX, 1'b1, '{STATUS_BAD_RANGE, 22'h0, 22'h0}},
		'{FUNC_FREE, ADDR_MAX, 22'h0, 22'h1, 1'b1, '{STATUS_BAD_RANGE, 22'h0, 22'h0}},
		'{FUNC_FREE, ADDR_MAX, ADDR_MAX, 22'h0, 1'b1, '{STATUS_BAD_RANGE, 22'h0, 22'h0}},
		// whole address space, taken in one go
		'{FUNC_FREE, 22'h0, ADDR_MAX, 22'h2aaaaa, 1'b1, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h155555, 22'h2aaaaa, ADDR_MAX, 1'b1, '{STATUS_OK, 22'h0, ADDR_MAX}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'h1, 1'b1, '{STATUS_NO_FIT, 22'h0, 22'h0}},
		// two ranges, head at the top of the space
		'{FUNC_FREE, 22'd100, 22'd200, 22'h3, 1'b1, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_FREE, ADDR_MAX - 22'd1, ADDR_MAX, 22'h0, 1'b1, '{STATUS_OK, 22'h0, 22'h0}},
		// zero size hits the head, then skip, exact fit, no fit
		'{FUNC_ALLOC, 22'h7, 22'h3, 22'd0, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd2, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd1, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd98, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_FREE, 22'd10, 22'd20, 22'h0, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_FREE, 22'd1000, 22'd1005, 22'h0, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_FREE, 22'd40, 22'd50, 22'h0, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd6, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd5, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd11, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd10, 1'b0, '{STATUS_OK, 22'h0, 22'h0}},
		'{FUNC_ALLOC, 22'h0, 22'h0, 22'd4, 1'b0, '{STATUS_OK, 22'h0, 22'h0}}
	};

	// stimulus
	initial begin
		int    rand_items;
		int    phase_kind;
		int    phase_len;
		int    free_pct;
		int    bad_pct;
		int    pick;
		int    idx;
		bit    first_phase;
		logic  func;
		addr_t rs;
		addr_t re;
		addr_t sz;
		addr_t span;
		rand_items  = 0;
		first_phase = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		m_tready <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[k]) begin
			send_item(dir_rows[k].func, dir_rows[k].rs, dir_rows[k].re, dir_rows[k].sz,
				dir_rows[k].fixed, dir_rows[k].res);
		end

		// random phases
		while (rand_items < RANDOM_ITEMS) begin
			phase_kind = first_phase ? PH_FILL : $urandom_range(PH_NOISE, PH_FILL);
			phase_len  = first_phase ? 20 : $urandom_range(60, 20);
			tx_idle_on <= ($urandom_range(3, 0) != 0);
			rx_idle_on <= ($urandom_range(3, 0) != 0);
			case (phase_kind)
				PH_FILL:  begin free_pct = first_phase ? 100 : 85; bad_pct = 5; end
				PH_DRAIN: begin free_pct = 10; bad_pct = 5; end
				PH_MIX:   begin free_pct = 45; bad_pct = 5; end
				default:  begin free_pct = 30; bad_pct = 30; end
			endcase
			for (int n = 0; n < phase_len; n++) begin
				pick = $urandom_range(99, 0);
				rs = addr_t'($urandom);
				re = addr_t'($urandom);
				sz = addr_t'($urandom);
				if (pick < free_pct) begin
					func = FUNC_FREE;
					if (phase_kind != PH_NOISE) begin
						// well-formed range of mostly modest length
						if (rs == ADDR_MAX)
							rs = rs - 1;
						case ($urandom_range(3, 0))
							0:       span = addr_t'($urandom_range(16, 1));
							1, 2:    span = addr_t'($urandom_range(4096, 1));
							default: span = addr_t'($urandom_range(ADDR_MAX, 1));
						endcase
						re = (ADDR_MAX - rs < span) ? ADDR_MAX : rs + span;
					end
				end else if (pick < free_pct + bad_pct) begin
					func = FUNC_FREE;
					re = addr_t'($urandom_range(rs, 0));
				end else begin
					func = FUNC_ALLOC;
					if (phase_kind != PH_NOISE) begin
						case ($urandom_range(5, 0))
							0, 1: begin
								if (used_count > 0) begin
									idx = $urandom_range(used_count - 1, 0);
									sz = free_hi[idx] - free_lo[idx];
								end
							end
							2, 3:    sz = addr_t'($urandom_range(64, 1));
							4:       sz = addr_t'($urandom_range(4096, 1));
							default: ;
						endcase
					end
					if (sz == 0)
						sz = 1;
				end
				send_item(func, rs, re, sz, 1'b0, '{STATUS_OK, '0, '0});
				rand_items++;
			end
			// hold off until the block has returned everything
			if (first_phase || $urandom_range(2, 0) == 0) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			first_phase = 1'b0;
		end

		// wind down
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
